// ===== sv/integer_matrix_multiply_assert.svh =====
// Assertion macros for the integer matrix multiply checker.
// Each macro takes a label, a clock, an active-low reset and two expressions.
`ifndef INTEGER_MATRIX_MULTIPLY_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("integer_matrix_multiply: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("integer_matrix_multiply: next-cycle check failed");

`endif

// ===== sv/imm_pkg.sv =====
// Shared types and constants of the integer matrix multiply block.
// No dependencies; every other file of the block but the assertion header imports it.
package imm_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned ELEM_W    = 16;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 4;

  // Reset value of each dimension register.
  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 4'd8;

  // Input commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2
  } imm_cmd_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS  = 2'd0,
    CFG_INNER = 2'd1,
    CFG_COLS  = 2'd2
  } imm_cfg_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } imm_state_e;

  // Store write request.
  typedef struct packed {
    logic              we_a;
    logic              we_b;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [ELEM_W-1:0] data;
  } imm_wr_t;

  // Multiply-accumulate control from the sequencer.
  typedef struct packed {
    logic             issue;
    logic             clear;
    logic [POS_W-1:0] i;
    logic [POS_W-1:0] j;
    logic [POS_W-1:0] k;
  } imm_mac_ctrl_t;

  // Multiply-accumulate status back to the sequencer.
  typedef struct packed {
    logic             busy;
    logic [ACC_W-1:0] acc;
  } imm_mac_stat_t;

endpackage

// ===== sv/imm_in_if.sv =====
// Input item channel of the integer matrix multiply block.
// Depends on imm_pkg for the field widths.
interface imm_in_if import imm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [POS_W-1:0]         row_index;
  logic [POS_W-1:0]         col_index;
  logic signed [ELEM_W-1:0] elem_value;

  modport source (output valid, command, row_index, col_index, elem_value, input ready);
  modport sink   (input valid, command, row_index, col_index, elem_value, output ready);
endinterface

// ===== sv/imm_out_if.sv =====
// Result channel of the integer matrix multiply block.
// Depends on imm_pkg for the field widths.
interface imm_out_if import imm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [POS_W-1:0]        out_row;
  logic [POS_W-1:0]        out_col;
  logic signed [ACC_W-1:0] out_value;
  logic                    is_last;

  modport source (output valid, out_row, out_col, out_value, is_last, input ready);
  modport sink   (input valid, out_row, out_col, out_value, is_last, output ready);
endinterface

// ===== sv/imm_cfg_if.sv =====
// Configuration write channel of the integer matrix multiply block.
// Depends on imm_pkg for the index and data widths.
interface imm_cfg_if import imm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/imm_mac.sv =====
// Element stores and the shared multiply-accumulate pipeline.
// Depends on imm_pkg for the control and status structs.
module imm_mac import imm_pkg::*; #(
  parameter int unsigned DIM_MAX   = 8,
  parameter int unsigned ELEM_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  imm_wr_t       wr_i,
  input  imm_mac_ctrl_t ctrl_i,
  output imm_mac_stat_t stat_o
);

  localparam int unsigned DEPTH  = DIM_MAX * DIM_MAX;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned PROD_W = 2 * ELEM_BITS;

  logic [ELEM_BITS-1:0] a_mem [DEPTH];
  logic [ELEM_BITS-1:0] b_mem [DEPTH];

  logic [ADDR_W-1:0]    waddr;
  logic [ADDR_W-1:0]    a_raddr;
  logic [ADDR_W-1:0]    b_raddr;
  logic                 wr_ok;
  logic [ELEM_BITS-1:0] wdata;

  logic [ELEM_BITS-1:0]     a_rd_q;
  logic [ELEM_BITS-1:0]     b_rd_q;
  logic                     rd_vld_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [63:0]       prod_ext;
  logic [ACC_W-1:0]         prod_q;
  logic                     mul_vld_q;
  logic [ACC_W-1:0]         acc_q;

  // Row-major addressing with a row stride of DIM_MAX.
  assign waddr   = ADDR_W'(wr_i.row * DIM_MAX + wr_i.col);
  assign a_raddr = ADDR_W'(ctrl_i.i * DIM_MAX + ctrl_i.j);
  assign b_raddr = ADDR_W'(ctrl_i.j * DIM_MAX + ctrl_i.k);
  assign wr_ok   = (wr_i.row < DIM_MAX) && (wr_i.col < DIM_MAX);

  // The stored element is the low ELEM_BITS bits of the written value, zero-extended if ELEM_BITS exceeds ELEM_W.
  if (ELEM_BITS <= ELEM_W) begin : g_narrow
    assign wdata = wr_i.data[ELEM_BITS-1:0];
  end else begin : g_wide
    assign wdata = {{(ELEM_BITS - ELEM_W){1'b0}}, wr_i.data};
  end

  // Store writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (wr_i.we_a && wr_ok) begin
      a_mem[waddr] <= wdata;
    end
    if (ctrl_i.issue) begin
      a_rd_q <= a_mem[a_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we_b && wr_ok) begin
      b_mem[waddr] <= wdata;
    end
    if (ctrl_i.issue) begin
      b_rd_q <= b_mem[b_raddr];
    end
  end

  // Full-width signed product, wrapped to the accumulator width.
  assign prod     = $signed(a_rd_q) * $signed(b_rd_q);
  assign prod_ext = 64'(prod);

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_q <= prod_ext[ACC_W-1:0];
    end
  end

  // Pipeline valid flags and the accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      mul_vld_q <= 1'b0;
      acc_q     <= '0;
    end else begin
      rd_vld_q  <= ctrl_i.issue;
      mul_vld_q <= rd_vld_q;
      if (ctrl_i.clear) begin
        acc_q <= '0;
      end else if (mul_vld_q) begin
        acc_q <= acc_q + prod_q;
      end
    end
  end

  assign stat_o.busy = rd_vld_q | mul_vld_q;
  assign stat_o.acc  = acc_q;

endmodule

// ===== sv/integer_matrix_multiply.sv =====
// Integer matrix multiply, top level: sequencer, dimension registers, result register.
// Depends on imm_pkg, the three channel interfaces and imm_mac.
//
// Usage:
//   in_i carries commands. Load A and load B write one element at (row, col)
//   and complete in the transfer cycle; a write outside DIM_MAX is dropped.
//   Compute forms C = A x B over the configured rows, inner length and
//   columns and sends one result per C element on out_o in row-major order,
//   with is_last set on the final one. Sums wrap in 32 bits.
//   cfg_i writes rows_used, inner_used and cols_used (index 0, 1, 2); it is
//   always ready. Values above DIM_MAX count as DIM_MAX.
// Timing:
//   One shared multiplier, one product per cycle while it issues. Each C
//   element goes through its issue cycles, the loop exit, the drain until the
//   pipeline is empty and the result register load; at an inner length of
//   zero there are no issue cycles. in_i is not ready while a compute runs.
// Stalls and reset: a stalled result holds in the output register, and the
//   next element waits in its emit cycle until that register is free. Reset
//   sets all dimensions to 8 and empties the result register; stores are undefined.
module integer_matrix_multiply import imm_pkg::*; #(
  parameter int unsigned DIM_MAX   = 8,
  parameter int unsigned ELEM_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  imm_in_if.sink    in_i,
  imm_out_if.source out_o,
  imm_cfg_if.sink   cfg_i
);

  localparam int unsigned DIM_W = $clog2(DIM_MAX + 1);

  imm_state_e state_q, state_d;

  logic [CFG_W-1:0] rows_q, inner_q, cols_q;
  logic [DIM_W-1:0] nr, ni, nc;
  logic [DIM_W-1:0] i_q, j_q, k_q;

  logic          in_fire;
  logic          start;
  logic          out_free;
  logic          emit;
  logic          last;
  imm_cmd_e      cmd;
  imm_wr_t       wr;
  imm_mac_ctrl_t ctrl;
  imm_mac_stat_t stat;

  logic                    out_vld_q;
  logic [POS_W-1:0]        out_row_q, out_col_q;
  logic signed [ACC_W-1:0] out_value_q;
  logic                    is_last_q;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= CFG_DIM_RESET;
      inner_q <= CFG_DIM_RESET;
      cols_q  <= CFG_DIM_RESET;
    end else if (cfg_i.valid) begin
      unique case (imm_cfg_e'(cfg_i.index))
        CFG_ROWS:  rows_q  <= cfg_i.data;
        CFG_INNER: inner_q <= cfg_i.data;
        CFG_COLS:  cols_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Dimensions in use, clamped to the store size.
  assign nr = (rows_q  > CFG_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : DIM_W'(rows_q);
  assign ni = (inner_q > CFG_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : DIM_W'(inner_q);
  assign nc = (cols_q  > CFG_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : DIM_W'(cols_q);

  // Command decode.
  assign cmd      = imm_cmd_e'(in_i.command);
  assign in_fire  = in_i.valid && in_i.ready;
  assign start    = in_fire && (cmd == CMD_COMPUTE) && (nr != '0) && (nc != '0);
  assign out_free = !out_vld_q || out_o.ready;
  assign last     = (i_q == nr - DIM_W'(1)) && (k_q == nc - DIM_W'(1));

  always_comb begin
    wr      = '0;
    wr.row  = in_i.row_index;
    wr.col  = in_i.col_index;
    wr.data = in_i.elem_value;
    unique case (cmd)
      CMD_LOAD_A:  wr.we_a = in_fire;
      CMD_LOAD_B:  wr.we_b = in_fire;
      CMD_COMPUTE: ;
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start) state_d = ST_MAC;
      ST_MAC:   if (j_q >= ni) state_d = ST_DRAIN;
      ST_DRAIN: if (!stat.busy) state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = last ? ST_IDLE : ST_MAC;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_i.ready = 1'b0;
    ctrl       = '0;
    emit       = 1'b0;
    ctrl.i     = POS_W'(i_q);
    ctrl.j     = POS_W'(j_q);
    ctrl.k     = POS_W'(k_q);
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        ctrl.clear = start;
      end
      ST_MAC:   ctrl.issue = (j_q < ni);
      ST_DRAIN: ;
      ST_EMIT: begin
        emit       = out_free;
        ctrl.clear = out_free;
      end
      default: ;
    endcase
  end

  // State and loop counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      if (start) begin
        i_q <= '0;
        j_q <= '0;
        k_q <= '0;
      end else if (ctrl.issue) begin
        j_q <= j_q + DIM_W'(1);
      end else if (emit) begin
        j_q <= '0;
        if (k_q == nc - DIM_W'(1)) begin
          k_q <= '0;
          i_q <= i_q + DIM_W'(1);
        end else begin
          k_q <= k_q + DIM_W'(1);
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_row_q   <= POS_W'(i_q);
      out_col_q   <= POS_W'(k_q);
      out_value_q <= stat.acc;
      is_last_q   <= last;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.out_row   = out_row_q;
  assign out_o.out_col   = out_col_q;
  assign out_o.out_value = out_value_q;
  assign out_o.is_last   = is_last_q;

  // Stores and the shared multiply-accumulate unit.
  imm_mac #(
    .DIM_MAX   (DIM_MAX),
    .ELEM_BITS (ELEM_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

endmodule

// ===== sv/imm_checker.sv =====
// Port-level checks of the integer matrix multiply block, with its bind.
// Depends on integer_matrix_multiply_assert.svh and imm_pkg.
`include "integer_matrix_multiply_assert.svh"

module imm_checker import imm_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [POS_W-1:0] out_row_i,
  input logic [POS_W-1:0] out_col_i,
  input logic [ACC_W-1:0] out_value_i,
  input logic             out_is_last_i
);

  // A stalled result stays offered and unchanged.
  `IMM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_row_i) && $stable(out_col_i) && $stable(out_value_i) && $stable(out_is_last_i))

  // A fresh result that is not the last one means the compute is still running.
  `IMM_ASSERT_IMP(a_busy_mid, clk_i, rst_ni, $rose(out_valid_i) && !out_is_last_i, !in_ready_i)

  // Leaving reset, the block is idle with no result pending.
  `IMM_ASSERT_IMP(a_reset_idle, clk_i, rst_ni, $rose(rst_ni), in_ready_i && !out_valid_i)

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_row_i     (out_o.out_row),
  .out_col_i     (out_o.out_col),
  .out_value_i   (out_o.out_value),
  .out_is_last_i (out_o.is_last)
);

// ===== sim/integer_matrix_multiply_test.sv =====
// Self-checking testbench for the integer matrix multiply block.
// Needs imm_pkg, the three channel interfaces and the block itself; it predicts
// every product element from its own copy of the stores and dimension registers.
`timescale 1ns / 100ps

module integer_matrix_multiply_test;
  import imm_pkg::*;

  localparam int DIM = 8;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 900;
  localparam int RANDOM_ITEMS = 300;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // One expected element of the product matrix.
  typedef struct {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [ACC_W-1:0] value;
    logic             last;
  } product_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  imm_in_if  in_ch();
  imm_out_if out_ch();
  imm_cfg_if cfg_ch();

  integer_matrix_multiply DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  // Predictor state: element stores and dimension registers.
  logic signed [ELEM_W-1:0] a_model[DIM*DIM];
  logic signed [ELEM_W-1:0] b_model[DIM*DIM];
  logic [CFG_W-1:0] rows_reg = CFG_DIM_RESET;
  logic [CFG_W-1:0] inner_reg = CFG_DIM_RESET;
  logic [CFG_W-1:0] cols_reg = CFG_DIM_RESET;

  product_t expected_products[$];
  bit zero_result_pending = 1'b0;
  bit bursts_on = 1'b1;
  int items_sent = 0;
  int products_checked = 0;
  int cfg_writes = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  // Forms the expected product elements for the current dimensions.
  function automatic void predict_products();
    int nr;
    int ni;
    int nc;
    logic [ACC_W-1:0] acc;
    product_t p;
    nr = (rows_reg > DIM) ? DIM : rows_reg;
    ni = (inner_reg > DIM) ? DIM : inner_reg;
    nc = (cols_reg > DIM) ? DIM : cols_reg;
    if (nr == 0 || nc == 0) zero_result_pending = 1'b1;
    for (int i = 0; i < nr; i++) begin
      for (int k = 0; k < nc; k++) begin
        acc = '0;
        for (int j = 0; j < ni; j++) begin
          acc = acc + ACC_W'(int'(a_model[i*DIM+j]) * int'(b_model[j*DIM+k]));
        end
        p.row = POS_W'(i);
        p.col = POS_W'(k);
        p.value = acc;
        p.last = (i == nr - 1) && (k == nc - 1);
        expected_products.push_back(p);
      end
    end
  endfunction

  // Element values lean toward the extremes of the 16-bit range.
  function automatic logic signed [ELEM_W-1:0] pick_elem();
    case ($urandom_range(0, 15))
      0, 1: return 16'sh8000;
      2, 3: return 16'sh7fff;
      4: return '0;
      5: return '1;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // Dimensions are mostly small, with some empty and some clamped settings.
  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_W'($urandom_range(5, 8));
      2: return CFG_W'($urandom_range(9, 15));
      default: return CFG_W'($urandom_range(1, 4));
    endcase
  endfunction

  // Sends one input item and updates the predictor on its transfer.
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] row,
                           logic [POS_W-1:0] col, logic signed [ELEM_W-1:0] val);
    int gap;
    @(negedge clk_i);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.command = cmd;
    in_ch.row_index = row;
    in_ch.col_index = col;
    in_ch.elem_value = val;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    case (cmd)
      CMD_LOAD_A: a_model[row*DIM+col] = val;
      CMD_LOAD_B: b_model[row*DIM+col] = val;
      CMD_COMPUTE: predict_products();
      default: ;
    endcase
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  // Compute command with random don't-care fields.
  task automatic send_compute();
    send_item(CMD_COMPUTE, POS_W'($urandom), POS_W'($urandom), ELEM_W'($urandom));
  endtask

  // Writes one dimension register through the configuration channel.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = val;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    case (idx)
      CFG_ROWS: rows_reg = val;
      CFG_INNER: inner_reg = val;
      CFG_COLS: cols_reg = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  // Holds off the sender until every expected product has arrived and a
  // compute that gave no result has had time to finish.
  task automatic settle();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (expected_products.size() != 0) @(posedge clk_i);
    repeat (zero_result_pending ? SETTLE_CYCLES : 8) @(posedge clk_i);
    zero_result_pending = 1'b0;
  endtask

  task automatic set_dims(logic [CFG_W-1:0] r, logic [CFG_W-1:0] n, logic [CFG_W-1:0] c);
    settle();
    write_register(CFG_ROWS, r);
    write_register(CFG_INNER, n);
    write_register(CFG_COLS, c);
  endtask

  // A run of random loads, some ignored items among them, then a compute.
  task automatic run_sequence(int loads);
    for (int n = 0; n < loads; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(CMD_UNUSED, POS_W'($urandom), POS_W'($urandom), pick_elem());
      end
      send_item($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A,
                POS_W'($urandom), POS_W'($urandom), pick_elem());
    end
    send_compute();
  endtask

  // Reset dimensions are eight by eight by eight; every entry gets written.
  task automatic test_reset_defaults();
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        send_item(CMD_LOAD_A, POS_W'(r), POS_W'(c), pick_elem());
        send_item(CMD_LOAD_B, POS_W'(r), POS_W'(c), pick_elem());
      end
    end
    send_compute();
  endtask

  // Extreme values; the top-left sum wraps past the positive limit.
  task automatic test_extreme_products();
    set_dims(4'd2, 4'd2, 4'd2);
    send_item(CMD_LOAD_A, 3'd0, 3'd0, 16'sh8000);
    send_item(CMD_LOAD_A, 3'd0, 3'd1, 16'sh8000);
    send_item(CMD_LOAD_A, 3'd1, 3'd0, 16'sh7fff);
    send_item(CMD_LOAD_A, 3'd1, 3'd1, -16'sd1);
    send_item(CMD_LOAD_B, 3'd0, 3'd0, 16'sh8000);
    send_item(CMD_LOAD_B, 3'd0, 3'd1, 16'sh7fff);
    send_item(CMD_LOAD_B, 3'd1, 3'd0, 16'sh8000);
    send_item(CMD_LOAD_B, 3'd1, 3'd1, 16'sd0);
    send_compute();
  endtask

  // Single element; an unused command code must leave the store alone.
  task automatic test_unit_dims();
    set_dims(4'd1, 4'd1, 4'd1);
    send_item(CMD_LOAD_A, 3'd0, 3'd0, 16'sh7fff);
    send_item(CMD_LOAD_B, 3'd0, 3'd0, -16'sd1);
    send_item(CMD_UNUSED, 3'd0, 3'd0, 16'sd0);
    send_item(CMD_LOAD_A, 3'd7, 3'd7, 16'sh5a5a);
    send_compute();
  endtask

  // An inner length of zero gives all-zero elements.
  task automatic test_zero_inner();
    set_dims(4'd3, 4'd0, 4'd2);
    send_compute();
  endtask

  // Zero rows or zero columns give no result; index three is not a register.
  task automatic test_empty_result();
    set_dims(4'd0, 4'd4, 4'd4);
    send_compute();
    set_dims(4'd4, 4'd4, 4'd0);
    write_register(CFG_UNUSED, CFG_W'($urandom));
    send_compute();
  endtask

  // Register values above eight count as eight.
  task automatic test_clamped_dims();
    set_dims(4'd15, 4'd9, 4'd12);
    send_compute();
  endtask

  // Rows, inner length and columns all differ.
  task automatic test_uneven_dims();
    set_dims(4'd3, 4'd5, 4'd2);
    send_compute();
    set_dims(4'd8, 4'd1, 4'd7);
    send_compute();
  endtask

  // Random dimension settings, each followed by a few load-compute runs.
  task automatic test_random_sequences(int target);
    int seqs;
    while (items_sent < target) begin
      set_dims(pick_dim(), pick_dim(), pick_dim());
      seqs = $urandom_range(1, 3);
      for (int s = 0; s < seqs; s++) run_sequence($urandom_range(1, 6));
    end
  endtask

  // Last stretch at full size with both sides streaming.
  task automatic test_calm_finish();
    set_dims(4'd8, 4'd8, 4'd8);
    bursts_on = 1'b0;
    for (int s = 0; s < 3; s++) run_sequence($urandom_range(3, 6));
  endtask

  // Receiver: random stall bursts while enabled.
  initial begin
    int stall_len;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rst_ni && bursts_on && $urandom_range(0, 5) == 0) begin
        stall_len = $urandom_range(1, 10);
        out_ch.ready = 1'b0;
        repeat (stall_len - 1) @(negedge clk_i);
      end else begin
        out_ch.ready = rst_ni;
      end
    end
  end

  // Result check: each transfer against the oldest expected product.
  always @(posedge clk_i) begin
    product_t exp_p;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_products.size() == 0) begin
        $display("%0t: unexpected result row %0d col %0d value %0d last %0d", $time,
                 out_ch.out_row, out_ch.out_col, out_ch.out_value, out_ch.is_last);
        mismatch_count++;
      end else begin
        exp_p = expected_products.pop_front();
        products_checked++;
        if (out_ch.out_row !== exp_p.row) begin
          $display("%0t: out_row expected %0d actual %0d", $time, exp_p.row, out_ch.out_row);
          mismatch_count++;
        end
        if (out_ch.out_col !== exp_p.col) begin
          $display("%0t: out_col expected %0d actual %0d", $time, exp_p.col, out_ch.out_col);
          mismatch_count++;
        end
        if (out_ch.out_value !== exp_p.value) begin
          $display("%0t: out_value expected %0d actual %0d", $time,
                   $signed(exp_p.value), out_ch.out_value);
          mismatch_count++;
        end
        if (out_ch.is_last !== exp_p.last) begin
          $display("%0t: is_last expected %0d actual %0d", $time, exp_p.last, out_ch.is_last);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_LOAD_A;
    in_ch.row_index = '0;
    in_ch.col_index = '0;
    in_ch.elem_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_ROWS;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_extreme_products();
    test_unit_dims();
    test_zero_inner();
    test_empty_result();
    test_clamped_dims();
    test_uneven_dims();
    test_random_sequences(RANDOM_ITEMS);
    test_calm_finish();

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_products.size() != 0) begin
      $display("%0t: %0d expected products never arrived", $time, expected_products.size());
      mismatch_count++;
    end
    $display("Sent %0d commands and %0d register writes; checked %0d product elements.",
             items_sent, cfg_writes, products_checked);
    $display("Covered extremes, wrapping, empty and clamped dimensions and random loads.");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== integer_matrix_multiply.f =====
+incdir+sv
sv/imm_pkg.sv
sv/imm_in_if.sv
sv/imm_out_if.sv
sv/imm_cfg_if.sv
sv/imm_mac.sv
sv/integer_matrix_multiply.sv
sv/imm_checker.sv
sim/integer_matrix_multiply_test.sv
